/* sv/dce_pkg.sv */
// Shared constants and word types for the curve evolution block.
`timescale 1ns / 1ps
`default_nettype none
package dce_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int REL_W      = 21;
  localparam logic [REL_W-1:0] REL_MAX = {REL_W{1'b1}};
  localparam int END_MUL    = 10;
  localparam int MIN_KEEP   = 3;

  // distance datapath widths
  localparam int U_W      = COORD_BITS + 1;
  localparam int SQ_W     = 2 * U_W;
  localparam int ROOT_TOP = 2 * COORD_BITS;
  localparam int D_W      = COORD_BITS + 1;
  localparam int RS_W     = D_W + 1;
  localparam int CALC_W   = (RS_W > REL_W) ? RS_W : REL_W;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic                         in_last;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic [IDX_W-1:0]             out_index;
    logic                         out_last;
  } out_word_t;

endpackage
`default_nettype wire

/* sv/dce_rel.sv */
// Relevance unit: three distances through one bit-serial square root.
`timescale 1ns / 1ps
`default_nettype none
module dce_rel (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire dce_pkg::point_t            pa,
  input  wire dce_pkg::point_t            pb,
  input  wire dce_pkg::point_t            pc,
  output logic                            done,
  output logic [dce_pkg::REL_W-1:0]       rel
);
  import dce_pkg::*;

  typedef enum logic [5:0] {
    R_IDLE = 6'b000001,
    R_DIFF = 6'b000010,
    R_SQ   = 6'b000100,
    R_SUM  = 6'b001000,
    R_ROOT = 6'b010000,
    R_FIN  = 6'b100000
  } rstate_t;

  localparam logic [1:0] PH_AB = 2'd0;
  localparam logic [1:0] PH_BC = 2'd1;
  localparam logic [1:0] PH_AC = 2'd2;

  rstate_t         st;
  point_t          p0, p1, p2;
  logic [1:0]      ph;
  logic [U_W-1:0]  ux, uy;
  logic [SQ_W-1:0] sx, sy;
  logic [SQ_W-1:0] rem, res, bitv;
  logic [D_W-1:0]  d0, d1;

  point_t          sa, sb;
  logic [U_W-1:0]  dx, dy;
  logic [SQ_W-1:0] trial, res_nxt;
  logic            ge;
  logic [RS_W-1:0] sum_s, d2_s, rdiff;
  logic [CALC_W-1:0] rwide;

  always_comb begin
    case (ph)
      PH_AB:   begin sa = p0; sb = p1; end
      PH_BC:   begin sa = p1; sb = p2; end
      default: begin sa = p0; sb = p2; end
    endcase
    dx = {sa.x[COORD_BITS-1], sa.x} - {sb.x[COORD_BITS-1], sb.x};
    dy = {sa.y[COORD_BITS-1], sa.y} - {sb.y[COORD_BITS-1], sb.y};
    if (dx[U_W-1]) dx = -dx;
    if (dy[U_W-1]) dy = -dy;
    trial   = res + bitv;
    ge      = rem >= trial;
    res_nxt = ge ? ((res >> 1) + bitv) : (res >> 1);
    sum_s   = {1'b0, d0} + {1'b0, d1};
    d2_s    = {1'b0, res[D_W-1:0]};
    rdiff   = (sum_s >= d2_s) ? (sum_s - d2_s) : (d2_s - sum_s);
    rwide   = CALC_W'(rdiff);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      st <= R_IDLE;
      ph <= PH_AB;
    end else begin
      unique case (st)
        R_IDLE: if (start) begin
          p0 <= pa; p1 <= pb; p2 <= pc;
          ph <= PH_AB;
          st <= R_DIFF;
        end
        R_DIFF: begin
          ux <= dx; uy <= dy;
          st <= R_SQ;
        end
        R_SQ: begin
          sx <= ux * ux; sy <= uy * uy;
          st <= R_SUM;
        end
        R_SUM: begin
          rem  <= sx + sy;
          res  <= '0;
          bitv <= SQ_W'(1) << ROOT_TOP;
          st   <= R_ROOT;
        end
        R_ROOT: begin
          if (ge) rem <= rem - trial;
          res  <= res_nxt;
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            if (ph == PH_AB) begin
              d0 <= res_nxt[D_W-1:0]; ph <= PH_BC; st <= R_DIFF;
            end else if (ph == PH_BC) begin
              d1 <= res_nxt[D_W-1:0]; ph <= PH_AC; st <= R_DIFF;
            end else begin
              st <= R_FIN;
            end
          end
        end
        R_FIN: begin
          rel  <= (rwide > CALC_W'(REL_MAX)) ? REL_MAX : rwide[REL_W-1:0];
          done <= 1'b1;
          st   <= R_IDLE;
        end
        default: st <= R_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/discrete_curve_evolution_top.sv */
// Top level: point load, relevance memories, removal sequencer and survivor output.
// Load: input words are taken in the load state; the word carrying in_last starts simplification,
// or output alone below MIN_KEEP points. Relevance: each value comes from the shared bit-serial root.
// Each removal: a scan over the live points plus up to two relevance updates.
// Output: every stored index is visited and each survivor is sent in turn, then loading resumes.
// Synchronous reset clears control, count, live mask and threshold; memories keep data.
`timescale 1ns / 1ps
`default_nettype none
module discrete_curve_evolution_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire dce_pkg::in_word_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output dce_pkg::out_word_t              out_data,
  input  wire logic                       cfg_we,
  input  wire logic [dce_pkg::REL_W-1:0]  cfg_wdata
);
  import dce_pkg::*;

  typedef enum logic [17:0] {
    S_LOAD   = 18'b1 << 0,
    S_PA     = 18'b1 << 1,
    S_PB     = 18'b1 << 2,
    S_PC     = 18'b1 << 3,
    S_RSTART = 18'b1 << 4,
    S_RWAIT  = 18'b1 << 5,
    S_END0   = 18'b1 << 6,
    S_END1   = 18'b1 << 7,
    S_SCAN0  = 18'b1 << 8,
    S_SCAN   = 18'b1 << 9,
    S_REMOVE = 18'b1 << 10,
    S_JNRD   = 18'b1 << 11,
    S_JNCAP  = 18'b1 << 12,
    S_CHECK  = 18'b1 << 13,
    S_EMRD   = 18'b1 << 14,
    S_EMWAIT = 18'b1 << 15,
    S_EMHOLD = 18'b1 << 16,
    S_SPARE  = 18'b1 << 17
  } state_t;

  typedef enum logic [1:0] {T_INIT, T_UPDI, T_UPDJ} tag_t;

  state_t state;
  tag_t   tag;

  // memories
  point_t           pt_mem  [MAX_POINTS];
  logic [REL_W-1:0] rel_mem [MAX_POINTS];
  logic [IDX_W-1:0] nxt_mem [MAX_POINTS];
  point_t           pt_q;
  logic [REL_W-1:0] rel_q;
  logic [IDX_W-1:0] nxt_q;

  logic             pt_we, rel_we, nxt_we;
  logic [IDX_W-1:0] pt_raddr, rel_raddr, rel_waddr, nxt_raddr, nxt_waddr, nxt_wdata;
  logic [REL_W-1:0] rel_wdata;

  logic [REL_W-1:0]      thr;
  logic [CNT_W-1:0]      cnt, n_pts, alive_cnt, s, em_k;
  logic [MAX_POINTS-1:0] alive_mask;
  logic [IDX_W-1:0]      tail, ra, rb, rc;
  logic [IDX_W-1:0]      cur, pcur, ppcur, me, me_i, me_ip, me_j;
  logic [REL_W-1:0]      minr, maxr;
  point_t                pa, pb;

  logic                  rel_start, rel_done;
  logic [REL_W-1:0]      rel_val;

  logic                  in_acc, space, has_next, em_last;
  logic [CNT_W-1:0]      cnt_after;
  logic [REL_W+3:0]      ends_full;
  logic [REL_W-1:0]      ends;
  logic [MAX_POINTS-1:0] above;

  dce_rel u_rel (
    .clk  (clk),
    .rst  (rst),
    .start(rel_start),
    .pa   (pa),
    .pb   (pb),
    .pc   (pt_q),
    .done (rel_done),
    .rel  (rel_val)
  );

  assign in_ready  = (state == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign space     = cnt < CNT_W'(MAX_POINTS);
  assign cnt_after = space ? cnt + 1'b1 : cnt;
  assign has_next  = (me != tail);
  assign rel_start = (state == S_RSTART);
  assign ends_full = (REL_W+4)'(maxr) * (REL_W+4)'(END_MUL);
  assign ends      = (ends_full > (REL_W+4)'(REL_MAX)) ? REL_MAX : ends_full[REL_W-1:0];
  assign above     = (alive_mask >> em_k[IDX_W-1:0]) >> 1;
  assign em_last   = (above == '0);

  always_comb begin
    pt_we     = in_acc && space;
    nxt_we    = 1'b0;
    nxt_waddr = cnt[IDX_W-1:0];
    nxt_wdata = cnt[IDX_W-1:0] + 1'b1;
    rel_we    = 1'b0;
    rel_waddr = rb;
    rel_wdata = rel_val;
    rel_raddr = '0;
    nxt_raddr = '0;
    pt_raddr  = ra;
    unique case (state)
      S_LOAD:   nxt_we = in_acc && space;
      S_PB:     pt_raddr = rb;
      S_PC:     pt_raddr = rc;
      S_RWAIT:  rel_we = rel_done;
      S_END0:   begin rel_we = 1'b1; rel_waddr = '0;   rel_wdata = ends; end
      S_END1:   begin rel_we = 1'b1; rel_waddr = tail; rel_wdata = ends; end
      S_SCAN:   begin rel_raddr = nxt_q; nxt_raddr = nxt_q; end
      S_REMOVE: begin
        nxt_we    = (me != '0) && has_next;
        nxt_waddr = me_i;
        nxt_wdata = me_j;
      end
      S_JNRD:   nxt_raddr = me_j;
      S_EMRD:   pt_raddr = em_k[IDX_W-1:0];
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[cnt[IDX_W-1:0]] <= '{y: in_data.in_y, x: in_data.in_x};
    pt_q <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rel_we) rel_mem[rel_waddr] <= rel_wdata;
    rel_q <= rel_mem[rel_raddr];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
    nxt_q <= nxt_mem[nxt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) thr <= '0;
    else if (cfg_we) thr <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      cnt        <= '0;
      alive_mask <= '0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: if (in_acc) begin
          if (space) begin
            alive_mask[cnt[IDX_W-1:0]] <= 1'b1;
            cnt <= cnt_after;
          end
          if (in_data.in_last) begin
            n_pts     <= cnt_after;
            alive_cnt <= cnt_after;
            tail      <= IDX_W'(cnt_after - 1'b1);
            ra <= IDX_W'(0); rb <= IDX_W'(1); rc <= IDX_W'(2);
            maxr <= '0;
            tag  <= T_INIT;
            em_k <= '0;
            state <= (cnt_after >= CNT_W'(MIN_KEEP)) ? S_PA : S_EMRD;
          end
        end
        S_PA: state <= S_PB;
        S_PB: begin pa <= pt_q; state <= S_PC; end
        S_PC: begin pb <= pt_q; state <= S_RSTART; end
        S_RSTART: state <= S_RWAIT;
        S_RWAIT: if (rel_done) begin
          case (tag)
            T_INIT: begin
              if (rel_val > maxr) maxr <= rel_val;
              if (rb == tail - 1'b1) state <= S_END0;
              else begin
                ra <= rb; rb <= rc; rc <= rc + 1'b1;
                state <= S_PA;
              end
            end
            T_UPDI:  state <= (me_j != tail) ? S_JNRD : S_CHECK;
            default: state <= S_CHECK;
          endcase
        end
        S_END0: state <= S_END1;
        S_END1: state <= S_SCAN0;
        S_SCAN0: begin
          s <= '0; cur <= '0; pcur <= '0; ppcur <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // first strict minimum along the live list
          if (s == '0) begin
            minr <= rel_q; me <= '0;
          end else if (rel_q < minr) begin
            minr <= rel_q; me <= cur; me_i <= pcur; me_ip <= ppcur; me_j <= nxt_q;
          end
          if (s == alive_cnt - 1'b1) state <= S_REMOVE;
          else begin
            ppcur <= pcur; pcur <= cur; cur <= nxt_q; s <= s + 1'b1;
          end
        end
        S_REMOVE: begin
          if (me == '0) state <= S_EMRD;
          else begin
            alive_mask[me] <= 1'b0;
            alive_cnt      <= alive_cnt - 1'b1;
            if (me_i == '0 || !has_next) state <= S_EMRD;
            else begin
              ra <= me_ip; rb <= me_i; rc <= me_j;
              tag <= T_UPDI;
              state <= S_PA;
            end
          end
        end
        S_JNRD: state <= S_JNCAP;
        S_JNCAP: begin
          ra <= me_i; rb <= me_j; rc <= nxt_q;
          tag <= T_UPDJ;
          state <= S_PA;
        end
        S_CHECK: begin
          if (alive_cnt <= CNT_W'(MIN_KEEP) || minr >= thr) state <= S_EMRD;
          else state <= S_SCAN0;
        end
        S_EMRD: begin
          if (em_k == n_pts) begin
            cnt        <= '0;
            alive_mask <= '0;
            state      <= S_LOAD;
          end else if (alive_mask[em_k[IDX_W-1:0]]) state <= S_EMWAIT;
          else em_k <= em_k + 1'b1;
        end
        S_EMWAIT: begin
          out_data.out_x     <= pt_q.x;
          out_data.out_y     <= pt_q.y;
          out_data.out_index <= em_k[IDX_W-1:0];
          out_data.out_last  <= em_last;
          out_valid          <= 1'b1;
          state              <= S_EMHOLD;
        end
        S_EMHOLD: if (out_ready) begin
          out_valid <= 1'b0;
          em_k      <= em_k + 1'b1;
          state     <= S_EMRD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while a word is on the output");
  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= CNT_W'(MAX_POINTS))
    else $error("point count past capacity");
  a_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ($countones(alive_mask) == int'(alive_cnt)))
    else $error("live count disagrees with live mask");
  a_min: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (alive_cnt >= CNT_W'(MIN_KEEP)))
    else $error("scan with too few live points");
  a_done: assert property (@(posedge clk) disable iff (rst) rel_done |-> (state == S_RWAIT))
    else $error("relevance finished outside the wait state");

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking bench for the curve evolution block: directed table, an overfull polyline, then random polylines.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import dce_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int TAIL_WAIT   = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [REL_W-1:0] cfg_wdata = '0;

  discrete_curve_evolution_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  point_t           pts [MAX_POINTS];
  logic [REL_W-1:0] rel [MAX_POINTS];
  int               nxt [MAX_POINTS];
  int               prv [MAX_POINTS];
  logic [MAX_POINTS-1:0] live;
  int               npts;
  logic [REL_W-1:0] thresh;

  out_word_t survivors_q[$];
  int  errors;
  int  cycles;
  bit  quiet;        // no idling in the last stretch
  bit  rx_stall;

  task automatic report(input string what, input out_word_t got, input out_word_t exp_w);
    errors++;
    $display("mismatch %s: got x=%0d y=%0d idx=%0d last=%0b, exp x=%0d y=%0d idx=%0d last=%0b",
             what, got.out_x, got.out_y, got.out_index, got.out_last,
             exp_w.out_x, exp_w.out_y, exp_w.out_index, exp_w.out_last);
  endtask

  function automatic longint root_floor(input longint v);
    longint r, b;
    r = 0;
    b = longint'(1) <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint span(input int a, input int b);
    longint dx, dy;
    dx = longint'(pts[a].x) - longint'(pts[b].x);
    dy = longint'(pts[a].y) - longint'(pts[b].y);
    return root_floor(dx * dx + dy * dy);
  endfunction

  function automatic logic [REL_W-1:0] bend(input int a, input int b, input int c);
    longint s, t, r;
    s = span(a, b) + span(b, c);
    t = span(a, c);
    r = (s >= t) ? s - t : t - s;
    return (r > longint'(REL_MAX)) ? REL_MAX : r[REL_W-1:0];
  endfunction

  function automatic void evolve(input int n);
    int tail, alive, cur, me, i, j;
    logic [REL_W-1:0] maxr, minr;
    longint ends;
    bit has_next;
    tail = n - 1;
    maxr = '0;
    for (int k = 0; k < n; k++) begin
      nxt[k] = (k + 1) & 63;
      prv[k] = (k - 1) & 63;
    end
    for (int k = 1; k < tail; k++) begin
      rel[k] = bend(k - 1, k, k + 1);
      if (rel[k] > maxr) maxr = rel[k];
    end
    ends = longint'(maxr) * END_MUL;
    if (ends > longint'(REL_MAX)) ends = REL_MAX;
    rel[0] = ends[REL_W-1:0];
    rel[tail] = ends[REL_W-1:0];
    alive = n;
    forever begin
      cur = 0;
      me = 0;
      minr = rel[0];
      for (int s = 1; s < alive; s++) begin
        cur = nxt[cur];
        if (rel[cur] < minr) begin
          minr = rel[cur];
          me = cur;
        end
      end
      if (me == 0) break;   // first point is minimum: stop
      i = prv[me];
      j = nxt[me];
      has_next = (me != tail);
      live[me] = 1'b0;
      alive--;
      if (has_next) begin
        nxt[i] = j;
        prv[j] = i;
      end
      if (i == 0 || !has_next) break;
      rel[i] = bend(prv[i], i, j);
      if (j != tail) rel[j] = bend(i, j, nxt[j]);
      if (alive <= MIN_KEEP) break;
      if (minr >= thresh) break;
    end
  endfunction

  function automatic void accept_point(input in_word_t w);
    int total, emitted;
    out_word_t o;
    if (npts < MAX_POINTS) begin
      pts[npts].x = w.in_x;
      pts[npts].y = w.in_y;
      live[npts] = 1'b1;
      npts++;
    end
    if (!w.in_last) return;
    if (npts >= MIN_KEEP) evolve(npts);
    total = 0;
    for (int k = 0; k < npts; k++) if (live[k]) total++;
    emitted = 0;
    for (int k = 0; k < npts; k++) begin
      if (!live[k]) continue;
      o.out_x = pts[k].x;
      o.out_y = pts[k].y;
      o.out_index = k[IDX_W-1:0];
      o.out_last = (emitted + 1 == total);
      survivors_q.insert(survivors_q.size(), o);
      emitted++;
    end
    npts = 0;
    live = '0;
  endfunction

  // cycle limit and receiver side
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  int rx_gap;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (survivors_q.size() == 0) begin
          report("unexpected word", out_data, '0);
        end else begin
          out_word_t e;
          e = survivors_q.pop_front();
          if (out_data.out_x !== e.out_x) report("out_x", out_data, e);
          else if (out_data.out_y !== e.out_y) report("out_y", out_data, e);
          else if (out_data.out_index !== e.out_index) report("out_index", out_data, e);
          else if (out_data.out_last !== e.out_last) report("out_last", out_data, e);
        end
      end
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet && rx_stall && $urandom_range(0, 7) == 0) begin
        rx_gap <= $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // send one word; optional burst of idling first
  task automatic send(input in_word_t w);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accept_point(w);
  endtask

  task automatic drain_and_set(input logic [REL_W-1:0] v);
    in_valid <= 1'b0;
    while (survivors_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    thresh = v;
  endtask

  task automatic send_line(input int n, input int mode);
    in_word_t w;
    int bx, by;
    bx = $urandom_range(0, 2000) - 1000;
    by = $urandom_range(0, 2000) - 1000;
    for (int k = 0; k < n; k++) begin
      case (mode)
        0: begin
          w.in_x = 16'($urandom);
          w.in_y = 16'($urandom);
        end
        1: begin  // gentle wiggle along a line
          w.in_x = 16'(bx + k * 50 + int'($urandom_range(0, 20)) - 10);
          w.in_y = 16'(by + int'($urandom_range(0, 40)) - 20);
        end
        default: begin  // extremes
          w.in_x = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
          w.in_y = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
        end
      endcase
      w.in_last = (k == n - 1);
      send(w);
    end
  endtask

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit last;
    bit known;
    int idx;
  } row_t;

  row_t plan[$];
  in_word_t w;
  int items;

  initial begin
    errors = 0;
    cycles = 0;
    npts = 0;
    live = '0;
    thresh = '0;
    quiet = 1'b0;
    rx_stall = 1'b1;
    // single point, pair, zig-zag with extremes, near-flat line with a small bump
    plan = '{
      '{16'sh7fff, 16'sh8000, 1, 1, 0},
      '{16'sh8000, 16'sh7fff, 0, 1, 0},
      '{16'sh0000, 16'sh0000, 1, 1, 1},
      '{16'sh8000, 16'sh8000, 0, 0, 0},
      '{16'sh7fff, 16'sh7fff, 0, 0, 0},
      '{16'sh8000, 16'sh7fff, 0, 0, 0},
      '{16'sh7fff, 16'sh8000, 0, 0, 0},
      '{16'sh0001, 16'shffff, 1, 0, 0},
      '{16'sh0000, 16'sh0000, 0, 0, 0},
      '{16'sh0001, 16'sh0000, 0, 0, 0},
      '{16'sh0002, 16'sh0001, 0, 0, 0},
      '{16'sh0003, 16'sh0000, 0, 0, 0},
      '{16'sh0004, 16'sh0000, 1, 0, 0}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    drain_and_set(REL_MAX);
    foreach (plan[r]) begin
      w.in_x = plan[r].x;
      w.in_y = plan[r].y;
      w.in_last = plan[r].last;
      send(w);
      // short polylines come straight back: check typed values against the queue
      if (plan[r].known && plan[r].last) begin
        out_word_t e;
        e = survivors_q[survivors_q.size() - 1];
        if (e.out_x !== plan[r].x || e.out_index != plan[r].idx || !e.out_last)
          report("table row", e, e);
      end
    end
    // overfull polyline: the words past the store limit are dropped, and the last one only ends it
    drain_and_set(21'd0);
    send_line(MAX_POINTS + 2, 1);
    items = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: drain_and_set(21'd0);
        1: drain_and_set(21'd30);
        2: drain_and_set(21'd2000);
        3: drain_and_set(REL_MAX);
        default: drain_and_set(REL_W'($urandom_range(0, 500)));
      endcase
      rx_stall = (ph != 2);
      for (int p = 0; p < 6; p++) begin
        int n, m;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_POINTS)
                                        : $urandom_range(1, 10);
        m = ($urandom_range(0, 5) == 0) ? 0 : (($urandom_range(0, 9) == 0) ? 2 : 1);
        if (ph == 4 && p >= 4) quiet = 1'b1;
        send_line(n, m);
        items += n;
      end
    end
    in_valid <= 1'b0;
    while (survivors_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
